>>> src/tilt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tilt_pkg
// Shared types, constants and the arctangent table of the tilt angle pipeline.
// ----------------------------------------------------------------------------
package tilt_pkg;

  localparam int unsigned ACC_W      = 33;
  localparam int unsigned TABLE_FRAC = 24;
  localparam int unsigned TABLE_LEN  = 24;
  localparam int unsigned PRESCALE   = 14;
  localparam int unsigned ANGLE_W    = 16;

  typedef logic signed [ACC_W-1:0] acc_t;

  typedef enum logic [1:0] {
    MODE_CORDIC = 2'd0,
    MODE_RIGHT  = 2'd1,
    MODE_ZERO   = 2'd2,
    MODE_UNDEF  = 2'd3
  } mode_t;

  typedef struct packed {
    logic  valid;
    logic  neg;
    mode_t mode;
  } tag_t;

  // atan(2^-idx) in degrees, units of 2^-24
  function automatic acc_t atan_tab(input int unsigned idx);
    acc_t v;
    case (idx)
      0:  v = 33'sd754974720;
      1:  v = 33'sd445687602;
      2:  v = 33'sd235489089;
      3:  v = 33'sd119537938;
      4:  v = 33'sd60000934;
      5:  v = 33'sd30029717;
      6:  v = 33'sd15018523;
      7:  v = 33'sd7509720;
      8:  v = 33'sd3754917;
      9:  v = 33'sd1877466;
      10: v = 33'sd938734;
      11: v = 33'sd469367;
      12: v = 33'sd234684;
      13: v = 33'sd117342;
      14: v = 33'sd58671;
      15: v = 33'sd29335;
      16: v = 33'sd14668;
      17: v = 33'sd7334;
      18: v = 33'sd3667;
      19: v = 33'sd1833;
      20: v = 33'sd917;
      21: v = 33'sd458;
      22: v = 33'sd229;
      23: v = 33'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> src/tilt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tilt_cell
// One vectoring micro-rotation with a fixed shift; registers its word onward.
// ----------------------------------------------------------------------------
module tilt_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  tilt_pkg::tag_t     tag_i,
  input  tilt_pkg::acc_t     x_i,
  input  tilt_pkg::acc_t     y_i,
  input  tilt_pkg::acc_t     z_i,
  output tilt_pkg::tag_t     tag_o,
  output tilt_pkg::acc_t     x_o,
  output tilt_pkg::acc_t     y_o,
  output tilt_pkg::acc_t     z_o
);

  localparam tilt_pkg::acc_t ANG = tilt_pkg::atan_tab(SHIFT);

  tilt_pkg::tag_t tag_r;
  tilt_pkg::acc_t x_r, y_r, z_r;
  tilt_pkg::acc_t x_nxt, y_nxt, z_nxt;
  tilt_pkg::acc_t xs, ys;

  always_comb begin
    xs = x_i >>> SHIFT;
    ys = y_i >>> SHIFT;
    if (!y_i[tilt_pkg::ACC_W-1]) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ANG;
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign tag_o = tag_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule
`default_nettype wire

>>> src/tilt_out.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tilt_out
// Rounds and clamps the accumulated angle, applies special cases and sign.
// ----------------------------------------------------------------------------
module tilt_out #(
  parameter int unsigned ANGLE_FRAC_BITS = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  tilt_pkg::tag_t                          tag_i,
  input  tilt_pkg::acc_t                          z_i,
  output logic                                    valid_o,
  output logic signed [tilt_pkg::ANGLE_W-1:0]     angle_o,
  output logic                                    undef_o
);

  localparam int unsigned SH = tilt_pkg::TABLE_FRAC - ANGLE_FRAC_BITS;
  localparam tilt_pkg::acc_t HALF = tilt_pkg::acc_t'(1) <<< (SH - 1);
  localparam tilt_pkg::acc_t FULL = tilt_pkg::acc_t'(90) <<< ANGLE_FRAC_BITS;

  logic                                valid_r;
  logic signed [tilt_pkg::ANGLE_W-1:0] angle_r, angle_nxt;
  logic                                undef_r, undef_nxt;
  tilt_pkg::acc_t                      zr, mag, sgn;

  always_comb begin
    zr = (z_i + HALF) >>> SH;
    if (zr[tilt_pkg::ACC_W-1]) begin
      mag = '0;
    end else if (zr > FULL) begin
      mag = FULL;
    end else begin
      mag = zr;
    end
    undef_nxt = 1'b0;
    case (tag_i.mode)
      tilt_pkg::MODE_CORDIC: begin
        sgn = mag;
      end
      tilt_pkg::MODE_RIGHT: begin
        sgn = FULL;
      end
      tilt_pkg::MODE_UNDEF: begin
        sgn       = '0;
        undef_nxt = 1'b1;
      end
      default: begin
        sgn = '0;
      end
    endcase
    if (tag_i.neg) begin
      sgn = -sgn;
    end
    angle_nxt = sgn[tilt_pkg::ANGLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= tag_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    angle_r <= angle_nxt;
    undef_r <= undef_nxt;
  end

  assign valid_o = valid_r;
  assign angle_o = angle_r;
  assign undef_o = undef_r;

endmodule
`default_nettype wire

>>> src/accel_tilt_angle_atan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// accel_tilt_angle_atan
// Tilt angle atan(Y/Z) in degrees from two accelerometer axes, CORDIC pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_accel_y / in_accel_z and raise start; the word is taken
//   at every rising edge with start high. busy is always low, so one pair
//   can enter every cycle.
//   Output: out_valid strobes for one cycle with out_angle_deg (signed,
//   2^-ANGLE_FRAC_BITS degree) and out_undefined_angle (both inputs zero).
//   Pipeline: one input stage, one cell per micro-rotation, one rounding
//   stage. Throughput: one word per cycle, set by the row of rotation
//   cells, each a single register stage.
//   Reset (rst_n low, synchronous) drops every word in flight; no results
//   appear until new words enter. The receiver cannot stall: each result is
//   shown once and must be taken in that cycle.
// ----------------------------------------------------------------------------
module accel_tilt_angle_atan #(
  parameter int unsigned ITERATIONS      = 16,
  parameter int unsigned ANGLE_FRAC_BITS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic signed [15:0]  in_accel_y,
  input  wire logic signed [15:0]  in_accel_z,
  output logic                     out_valid,
  output logic signed [15:0]       out_angle_deg,
  output logic                     out_undefined_angle
);

  localparam int unsigned NCELLS =
    (ITERATIONS < tilt_pkg::TABLE_LEN) ? ITERATIONS : tilt_pkg::TABLE_LEN;
  localparam int unsigned LAT = NCELLS + 2;

  tilt_pkg::tag_t tag_c [NCELLS+1];
  tilt_pkg::acc_t x_c   [NCELLS+1];
  tilt_pkg::acc_t y_c   [NCELLS+1];
  tilt_pkg::acc_t z_c   [NCELLS+1];

  tilt_pkg::tag_t       tag0_r, tag0_nxt;
  tilt_pkg::acc_t       x0_r, x0_nxt, y0_r, y0_nxt;
  logic signed [16:0]   ay, az;

  assign busy = 1'b0;

  always_comb begin
    ay = in_accel_y[15] ? -{in_accel_y[15], in_accel_y} : {in_accel_y[15], in_accel_y};
    az = in_accel_z[15] ? -{in_accel_z[15], in_accel_z} : {in_accel_z[15], in_accel_z};
    x0_nxt = tilt_pkg::acc_t'(az) <<< tilt_pkg::PRESCALE;
    y0_nxt = tilt_pkg::acc_t'(ay) <<< tilt_pkg::PRESCALE;
    tag0_nxt.valid = start;
    tag0_nxt.neg   = in_accel_y[15] ^ in_accel_z[15];
    if (in_accel_y == '0 && in_accel_z == '0) begin
      tag0_nxt.mode = tilt_pkg::MODE_UNDEF;
    end else if (in_accel_z == '0) begin
      tag0_nxt.mode = tilt_pkg::MODE_RIGHT;
    end else if (in_accel_y == '0) begin
      tag0_nxt.mode = tilt_pkg::MODE_ZERO;
    end else begin
      tag0_nxt.mode = tilt_pkg::MODE_CORDIC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag0_r <= '0;
    end else begin
      tag0_r <= tag0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x0_r <= x0_nxt;
    y0_r <= y0_nxt;
  end

  assign tag_c[0] = tag0_r;
  assign x_c[0]   = x0_r;
  assign y_c[0]   = y0_r;
  assign z_c[0]   = '0;

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    tilt_cell #(
      .SHIFT (i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tag_i (tag_c[i]),
      .x_i   (x_c[i]),
      .y_i   (y_c[i]),
      .z_i   (z_c[i]),
      .tag_o (tag_c[i+1]),
      .x_o   (x_c[i+1]),
      .y_o   (y_c[i+1]),
      .z_o   (z_c[i+1])
    );
  end

  tilt_out #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_i   (tag_c[NCELLS]),
    .z_i     (z_c[NCELLS]),
    .valid_o (out_valid),
    .angle_o (out_angle_deg),
    .undef_o (out_undefined_angle)
  );

  a_strobe_follows_start : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result strobe without an accepted word");

  a_undef_zero_angle : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_undefined_angle) |-> (out_angle_deg == '0))
    else $error("undefined angle with nonzero value");

  a_undef_from_zero_in : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_undefined_angle) |->
      ($past(in_accel_y, LAT) == '0 && $past(in_accel_z, LAT) == '0))
    else $error("undefined flag for nonzero inputs");

endmodule
`default_nettype wire
